// File: rtl/core/tdpc_pkg.sv
// shared constants for the trial division prime counter
// no dependencies; imported by the top level

package tdpc_pkg;

  // default widths for the top-level parameters
  localparam int LIMIT_BITS_DEF  = 16;
  localparam int WORKER_BITS_DEF = 8;

  // result field
  localparam int          COUNT_BITS = 16;
  localparam logic [15:0] COUNT_MAX  = 16'hFFFF;

  // first candidate and first trial divisor
  localparam int FIRST_CAND = 2;

  // configuration register indexes
  localparam logic REG_WORKER_INDEX = 1'b0;
  localparam logic REG_WORKER_COUNT = 1'b1;

endpackage

// File: rtl/core/tdpc_rem_unit.sv
// shared remainder unit: restoring division, one quotient bit per cycle
// no package dependencies; used by trial_division_prime_counter_unit

module tdpc_rem_unit #(
  parameter int WIDTH = 18
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [WIDTH-1:0] dividend,
  input  logic [WIDTH-1:0] divisor,
  output logic             done,
  output logic [WIDTH-1:0] remainder
);

  localparam int STEP_BITS = $clog2(WIDTH + 1);

  logic [WIDTH-1:0]     dvd_r, dvd_nxt;
  logic [WIDTH-1:0]     dsr_r, dsr_nxt;
  logic [WIDTH-1:0]     rem_r, rem_nxt;
  logic [STEP_BITS-1:0] step_r, step_nxt;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [WIDTH:0]       trial;
  logic [WIDTH:0]       diff;

  // one shift, compare and subtract step
  assign trial = {rem_r, dvd_r[WIDTH-1]};
  assign diff  = trial - {1'b0, dsr_r};

  always_comb begin
    dvd_nxt  = dvd_r;
    dsr_nxt  = dsr_r;
    rem_nxt  = rem_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      dvd_nxt  = dividend;
      dsr_nxt  = divisor;
      rem_nxt  = '0;
      step_nxt = STEP_BITS'(WIDTH);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      dvd_nxt  = {dvd_r[WIDTH-2:0], 1'b0};
      rem_nxt  = (trial >= {1'b0, dsr_r}) ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
      step_nxt = step_r - STEP_BITS'(1);
      if (step_r == STEP_BITS'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    dsr_r <= dsr_nxt;
    rem_r <= rem_nxt;
  end

  assign done      = done_r;
  assign remainder = rem_r;

endmodule

// File: rtl/core/trial_division_prime_counter_unit.sv
// top level: snake-order candidate deal, trial division sequencer, result register
// depends on tdpc_pkg and tdpc_rem_unit
//
// a prime candidate c is tried against every divisor from 2 to floor(sqrt(c)), a composite
//   with smallest factor p against 2 to p; the shared remainder unit is CW = max(LIMIT_BITS,
//   WORKER_BITS + 1) + 2 bits wide
// throughput: one limit at a time; in_tready is high only while idle, a held result stalls it
// reset: synchronous active-low rst_n; worker_index resets to 0, worker_count to 1

module trial_division_prime_counter_unit
  import tdpc_pkg::*;
#(
  parameter int LIMIT_BITS  = LIMIT_BITS_DEF,
  parameter int WORKER_BITS = WORKER_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // input channel
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [((LIMIT_BITS+7)/8)*8-1:0]     in_tdata,   // [LIMIT_BITS-1:0] upper_limit
  // result channel
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [COUNT_BITS-1:0]               out_tdata,  // [15:0] prime_count
  // configuration port
  input  logic                                cfg_we,
  input  logic                                cfg_index,
  input  logic [WORKER_BITS:0]                cfg_wdata
);

  localparam int MAXB = (LIMIT_BITS > WORKER_BITS + 1) ? LIMIT_BITS : WORKER_BITS + 1;
  localparam int CW   = MAXB + 2;
  localparam int SW   = CW + 2;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_ROW  = 3'd1;
  localparam logic [2:0] ST_TEST = 3'd2;
  localparam logic [2:0] ST_WAIT = 3'd3;
  localparam logic [2:0] ST_NEXT = 3'd4;
  localparam logic [2:0] ST_FIN  = 3'd5;

  logic [WORKER_BITS-1:0] widx_r;
  logic [WORKER_BITS:0]   wcnt_r;

  logic [2:0]            state_r, state_nxt;
  logic [LIMIT_BITS-1:0] limit_r, limit_nxt;
  logic [CW-1:0]         base_r, base_nxt;
  logic                  odd_r, odd_nxt;
  logic [CW-1:0]         cand_r, cand_nxt;
  logic [CW-1:0]         div_r, div_nxt;
  logic [SW-1:0]         sq_r, sq_nxt;
  logic [COUNT_BITS-1:0] cnt_r, cnt_nxt;
  logic                  oval_r, oval_nxt;
  logic [COUNT_BITS-1:0] odata_r, odata_nxt;

  logic [WORKER_BITS:0]  offset;
  logic [CW-1:0]         cand_row;
  logic                  rem_start;
  logic                  rem_done;
  logic [CW-1:0]         rem_val;
  logic [COUNT_BITS-1:0] cnt_inc;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      widx_r <= '0;
      wcnt_r <= (WORKER_BITS+1)'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WORKER_INDEX: widx_r <= cfg_wdata[WORKER_BITS-1:0];
        REG_WORKER_COUNT: wcnt_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // snake-order offset and candidate of the current row
  assign offset   = odd_r ? (wcnt_r - (WORKER_BITS+1)'(1) - {1'b0, widx_r})
                          : {1'b0, widx_r};
  assign cand_row = base_r + CW'(offset);

  assign cnt_inc  = (cnt_r == COUNT_MAX) ? cnt_r : cnt_r + COUNT_BITS'(1);

  // sequencer
  always_comb begin
    state_nxt = state_r;
    limit_nxt = limit_r;
    base_nxt  = base_r;
    odd_nxt   = odd_r;
    cand_nxt  = cand_r;
    div_nxt   = div_r;
    sq_nxt    = sq_r;
    cnt_nxt   = cnt_r;
    oval_nxt  = oval_r;
    odata_nxt = odata_r;
    rem_start = 1'b0;

    // result register drains independently of the sequencer
    if (oval_r && out_tready) begin
      oval_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          limit_nxt = in_tdata[LIMIT_BITS-1:0];
          base_nxt  = CW'(FIRST_CAND);
          odd_nxt   = 1'b0;
          cnt_nxt   = '0;
          state_nxt = ({1'b0, widx_r} < wcnt_r) ? ST_ROW : ST_FIN;
        end
      end
      ST_ROW: begin
        if (cand_row >= CW'(limit_r)) begin
          state_nxt = ST_FIN;
        end else begin
          cand_nxt  = cand_row;
          div_nxt   = CW'(FIRST_CAND);
          sq_nxt    = SW'(FIRST_CAND * FIRST_CAND);
          state_nxt = ST_TEST;
        end
      end
      ST_TEST: begin
        if (sq_r > SW'(cand_r)) begin
          // no divisor up to the square root: prime
          cnt_nxt   = cnt_inc;
          state_nxt = ST_NEXT;
        end else begin
          rem_start = 1'b1;
          state_nxt = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (rem_done) begin
          if (rem_val == '0) begin
            state_nxt = ST_NEXT;
          end else begin
            // (d+1)^2 = d^2 + 2d + 1
            sq_nxt    = sq_r + SW'({div_r, 1'b0}) + SW'(1);
            div_nxt   = div_r + CW'(1);
            state_nxt = ST_TEST;
          end
        end
      end
      ST_NEXT: begin
        base_nxt  = base_r + CW'(wcnt_r);
        odd_nxt   = ~odd_r;
        state_nxt = ST_ROW;
      end
      ST_FIN: begin
        if (!oval_r || out_tready) begin
          oval_nxt  = 1'b1;
          odata_nxt = cnt_r;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      oval_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      oval_r  <= oval_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    limit_r <= limit_nxt;
    base_r  <= base_nxt;
    odd_r   <= odd_nxt;
    cand_r  <= cand_nxt;
    div_r   <= div_nxt;
    sq_r    <= sq_nxt;
    cnt_r   <= cnt_nxt;
    odata_r <= odata_nxt;
  end

  // shared remainder unit
  tdpc_rem_unit #(
    .WIDTH (CW)
  ) u_rem (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (rem_start),
    .dividend  (cand_r),
    .divisor   (div_r),
    .done      (rem_done),
    .remainder (rem_val)
  );

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = oval_r;
  assign out_tdata  = odata_r;

endmodule

// File: tb/sv/tb_trial_division_prime_counter_unit.sv
// testbench for trial_division_prime_counter_unit: directed and random limits over
// several worker shares, with a scoreboard that predicts each prime count
// depends on tdpc_pkg and the trial_division_prime_counter_unit rtl

module tb_trial_division_prime_counter_unit;
  import tdpc_pkg::*;

  localparam int LIMIT_W      = LIMIT_BITS_DEF;
  localparam int WORKER_W     = WORKER_BITS_DEF;
  localparam int DATA_W       = ((LIMIT_W + 7) / 8) * 8;
  localparam int CYCLE_LIMIT  = 30_000_000;
  localparam int DRAIN_CYCLES = 8;
  localparam int RANDOM_ITEMS = 75;
  localparam int STEADY_ITEMS = 20;
  localparam int HOLD_CYCLES  = 3000;

  // scoreboard: copy of the share registers and the queue of expected counts
  class prime_count_board;
    logic [WORKER_W-1:0]   widx;
    logic [WORKER_W:0]     wcnt;
    logic [COUNT_BITS-1:0] pending[$];
    int                    errors;

    function new();
      widx   = '0;
      wcnt   = (WORKER_W+1)'(1);
      errors = 0;
    endfunction

    function void set_register(logic idx, logic [WORKER_W:0] val);
      if (idx == REG_WORKER_INDEX) begin
        widx = val[WORKER_W-1:0];
      end else begin
        wcnt = val;
      end
    endfunction

    // walk the snake-order share and count primes found by trial division
    function logic [COUNT_BITS-1:0] count_share_primes(logic [LIMIT_W-1:0] lim);
      int unsigned row, cand, offs, d, cnt;
      bit          done, prime;
      cnt  = 0;
      row  = 0;
      done = 1'b0;
      if (widx < wcnt) begin
        while (!done) begin
          offs = row[0] ? (wcnt - 1 - widx) : widx;
          cand = FIRST_CAND + row * wcnt + offs;
          if (cand >= lim) begin
            done = 1'b1;
          end else begin
            prime = 1'b1;
            d     = FIRST_CAND;
            while (prime && d * d <= cand) begin
              if (cand % d == 0) prime = 1'b0;
              else d++;
            end
            if (prime && cnt < COUNT_MAX) cnt++;
            row++;
          end
        end
      end
      return cnt[COUNT_BITS-1:0];
    endfunction

    function void note_limit(logic [LIMIT_W-1:0] lim);
      pending.push_back(count_share_primes(lim));
    endfunction

    function void check_count(logic [COUNT_BITS-1:0] act);
      logic [COUNT_BITS-1:0] exp_cnt;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: unexpected prime_count transaction, expected none, actual %0d",
                 $time, act);
      end else begin
        exp_cnt = pending.pop_front();
        if (act !== exp_cnt) begin
          errors++;
          $display("%0t: prime_count mismatch, expected %0d, actual %0d",
                   $time, exp_cnt, act);
        end
      end
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [DATA_W-1:0]   in_tdata;     // [15:0] upper_limit
  logic                out_tvalid;
  logic                out_tready;
  logic [COUNT_BITS-1:0] out_tdata;  // [15:0] prime_count
  logic                cfg_we;
  logic                cfg_index;
  logic [WORKER_W:0]   cfg_wdata;

  prime_count_board board;
  bit               steady;
  int               hold_left;
  int               cycles;

  trial_division_prime_counter_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // cycle limit
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Some tests failed");
    $finish;
  end

  // result receiver: long hold-off on request, random stall bursts otherwise
  initial begin
    int burst_left;
    burst_left = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_tready = 1'b0;
        hold_left--;
      end else if (burst_left > 0) begin
        out_tready = 1'b0;
        burst_left--;
      end else if (!steady && $urandom_range(0, 7) == 0) begin
        out_tready = 1'b0;
        burst_left = $urandom_range(1, 11) - 1;
      end else begin
        out_tready = 1'b1;
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) board.check_count(out_tdata);
  end

  // one limit transaction, with an optional idle burst in front
  task automatic send_limit(input logic [LIMIT_W-1:0] lim);
    int gap;
    if (!steady && $urandom_range(0, 3) == 0) begin
      gap       = $urandom_range(1, 11);
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = DATA_W'(lim);
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    board.note_limit(lim);
    @(negedge clk);
  endtask

  // write both share registers on consecutive cycles
  task automatic set_share(input logic [WORKER_W:0] idx_val, input logic [WORKER_W:0] cnt_val);
    cfg_we    = 1'b1;
    cfg_index = REG_WORKER_INDEX;
    cfg_wdata = idx_val;
    @(negedge clk);
    board.set_register(REG_WORKER_INDEX, idx_val);
    cfg_index = REG_WORKER_COUNT;
    cfg_wdata = cnt_val;
    @(negedge clk);
    board.set_register(REG_WORKER_COUNT, cnt_val);
    cfg_we = 1'b0;
  endtask

  // stop offering and wait for every expected count
  task automatic wait_drained;
    in_tvalid = 1'b0;
    while (board.pending.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // limits kept small against the share so each scan stays short
  function automatic logic [LIMIT_W-1:0] pick_limit();
    int unsigned top;
    if (board.widx >= board.wcnt) return LIMIT_W'($urandom_range(0, 65535));
    top = board.wcnt * 48;
    if (top > 65535) top = 65535;
    if ($urandom_range(0, 9) == 0) return LIMIT_W'($urandom_range(0, 3));
    return LIMIT_W'($urandom_range(0, top));
  endfunction

  initial begin
    int unsigned r, cnt, idx, n;
    int          sent;
    board     = new();
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    cfg_we    = 1'b0;
    cfg_index = REG_WORKER_INDEX;
    cfg_wdata = '0;
    steady    = 1'b0;
    hold_left = 0;
    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    // reset share: a single worker counts every prime, small limits give zero
    send_limit(16'd0);
    send_limit(16'd1);
    send_limit(16'd2);
    send_limit(16'd3);
    send_limit(16'd4);
    send_limit(16'd5);
    send_limit(16'd6);
    send_limit(16'd30);
    send_limit(16'd1000);
    wait_drained;

    // widest regular share, first and last worker
    set_share(9'd0, 9'd256);
    send_limit(16'hFFFF);
    send_limit(16'h8000);
    wait_drained;
    set_share(9'd255, 9'd256);
    send_limit(16'hFFFF);
    send_limit(16'd257);
    wait_drained;

    // count above 256 used as given, index bit above the register dropped
    set_share(9'h1FF, 9'h1FF);
    send_limit(16'hFFFF);
    wait_drained;

    // index not below count gives an empty share
    set_share(9'd5, 9'd0);
    send_limit(16'hFFFF);
    send_limit(16'd0);
    wait_drained;
    set_share(9'd200, 9'd3);
    send_limit(16'hAAAA);
    send_limit(16'h5555);
    wait_drained;

    // snake order across three workers
    set_share(9'd2, 9'd3);
    send_limit(16'd300);
    send_limit(16'd301);
    wait_drained;

    // receiver holds off while the sender keeps offering
    set_share(9'd0, 9'd1);
    hold_left = HOLD_CYCLES;
    repeat (6) send_limit(LIMIT_W'($urandom_range(0, 40)));
    wait_drained;

    // random shares and limits, no idling in the last stretch
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      r = $urandom_range(0, 9);
      if (r < 4) begin
        cnt = $urandom_range(1, 8);
        idx = $urandom_range(0, cnt - 1);
      end else if (r < 8) begin
        cnt = $urandom_range(1, 511);
        idx = $urandom_range(0, (cnt > 256) ? 255 : cnt - 1);
      end else begin
        cnt = $urandom_range(0, 511);
        idx = $urandom_range(0, 511);
      end
      set_share((WORKER_W+1)'(idx), (WORKER_W+1)'(cnt));
      n = $urandom_range(4, 12);
      repeat (n) begin
        steady = (sent >= RANDOM_ITEMS - STEADY_ITEMS);
        send_limit(pick_limit());
        sent++;
      end
      wait_drained;
    end

    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
